### hw/rtl/pcbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants of the prefix code bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

    localparam int WORD_BITS = 32;  // width of the code word port
    localparam int LEN_W     = 6;   // width of a code length
    localparam int SYM_W     = 8;   // width of a symbol
    localparam int BYTE_W    = 8;   // width of an output byte
    localparam int CNT_W     = 3;   // width of the pending bit count
    localparam int PEND_W    = 7;   // width of the pending bit store

    // Item modes; the fourth code is unused and ignored
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT,
        ST_FLUSH_DATA,
        ST_FLUSH_END
    } state_t;

    // Commands from the sequencer to the byte shifter
    typedef struct packed {
        logic load;    // take pending bits plus the looked-up code
        logic step;    // drop the low byte
        logic settle;  // move the leftover bits back to the pending store
        logic clear;   // empty the pending store
    } pcbp_ctrl_t;

    // Status from the byte shifter to the sequencer
    typedef struct packed {
        logic                has_byte;    // eight or more bits gathered
        logic                final_byte;  // fewer than sixteen bits gathered
        logic [BYTE_W-1:0]   byte_data;
        logic [PEND_W-1:0]   pend_bits;
        logic [CNT_W-1:0]    pend_count;
    } pcbp_stat_t;

endpackage
`default_nettype wire

### hw/rtl/pcbp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output      logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/pcbp_code_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_code_table
// Code word and length store with per-entry valid bits; an entry never
// loaded since reset reads as zero length.
// ----------------------------------------------------------------------------
module pcbp_code_table
    import pcbp_pkg::*;
#(
    parameter int CODE_W       = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [$clog2(SYMBOL_COUNT)-1:0]   wr_addr,
    input  wire logic [WORD_BITS-1:0]              wr_word,
    input  wire logic [LEN_W-1:0]                  wr_len,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(SYMBOL_COUNT)-1:0]   rd_addr,
    output      logic [CODE_W-1:0]                 rd_word,
    output      logic [LEN_W-1:0]                  rd_len
);

    localparam int ENTRY_W = CODE_W + LEN_W;

    logic [SYMBOL_COUNT-1:0] vld_reg;
    logic                    rd_vld_reg;
    logic [LEN_W-1:0]        len_sat;
    logic [CODE_W-1:0]       word_mask;
    logic [ENTRY_W-1:0]      wr_entry;
    logic [ENTRY_W-1:0]      rd_entry;

    // Saturate the length and clear code bits at or above it
    always_comb
    begin
        if (wr_len > LEN_W'(CODE_W))
        begin
            len_sat = LEN_W'(CODE_W);
        end
        else
        begin
            len_sat = wr_len;
        end
        for (int i = 0; i < CODE_W; i++)
        begin
            word_mask[i] = (LEN_W'(i) < len_sat);
        end
        wr_entry = {len_sat, wr_word[CODE_W-1:0] & word_mask};
    end

    pcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_word = rd_entry[CODE_W-1:0];
    assign rd_len  = rd_vld_reg ? rd_entry[ENTRY_W-1:CODE_W] : '0;

endmodule
`default_nettype wire

### hw/rtl/pcbp_shift_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_shift_unit
// Bit accumulator and byte shifter; holds the pending bits between items.
// ----------------------------------------------------------------------------
module pcbp_shift_unit
    import pcbp_pkg::*;
#(
    parameter int CODE_W = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pcbp_ctrl_t            ctrl,
    input  wire logic [CODE_W-1:0]     code_word,
    input  wire logic [LEN_W-1:0]      code_len,
    output      pcbp_stat_t            stat
);

    localparam int ACC_W = CODE_W + PEND_W;

    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [LEN_W-1:0]  total_reg;
    logic [LEN_W-1:0]  total_next;
    logic [PEND_W-1:0] pend_bits_reg;
    logic [PEND_W-1:0] pend_bits_next;
    logic [CNT_W-1:0]  pend_count_reg;
    logic [CNT_W-1:0]  pend_count_next;

    always_comb
    begin
        acc_next        = acc_reg;
        total_next      = total_reg;
        pend_bits_next  = pend_bits_reg;
        pend_count_next = pend_count_reg;
        if (ctrl.load)
        begin
            // append the code above the pending bits
            acc_next   = ACC_W'(pend_bits_reg) | (ACC_W'(code_word) << pend_count_reg);
            total_next = LEN_W'(pend_count_reg) + code_len;
        end
        else if (ctrl.step)
        begin
            acc_next   = acc_reg >> BYTE_W;
            total_next = total_reg - LEN_W'(BYTE_W);
        end
        if (ctrl.settle)
        begin
            pend_bits_next  = acc_reg[PEND_W-1:0];
            pend_count_next = total_reg[CNT_W-1:0];
        end
        else if (ctrl.clear)
        begin
            pend_bits_next  = '0;
            pend_count_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= '0;
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
        end
        else
        begin
            total_reg      <= total_next;
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
        end
    end

    assign stat.has_byte   = (total_reg >= LEN_W'(BYTE_W));
    assign stat.final_byte = (total_reg < LEN_W'(2 * BYTE_W));
    assign stat.byte_data  = acc_reg[BYTE_W-1:0];
    assign stat.pend_bits  = pend_bits_reg;
    assign stat.pend_count = pend_count_reg;

endmodule
`default_nettype wire

### hw/rtl/prefix_code_bit_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_code_bit_packer
// Back end of a prefix (Huffman) encoder: code table, bit gathering and
// byte output.
// ----------------------------------------------------------------------------
// A load item writes one code table entry; the block stays ready for the
// next item. An encode item reads the table (registered read), merges the
// code with the pending bits in the shifter, then the shifter gives one byte
// per cycle while the output side takes them, then moves the leftover bits
// back into the pending store: an encode item of a symbol with a code gives
// 0 to 4 bytes. An encode of a symbol without a code gives no bytes and goes
// through accept and table read only. An encode of a symbol outside the
// table, like an unused mode, gives nothing and is dropped in the cycle it
// is accepted. A flush item goes through accept, data byte and end byte.
// An item that wants to emit waits while the output register still holds a
// byte the sink has not taken. The one output register lets a byte wait for
// the sink while the shifter holds the next one. Table entries read as zero
// length until loaded after reset.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer
    import pcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input item channel
    input  wire logic                  item_valid,
    output      logic                  item_ready,
    input  wire logic [1:0]            mode,
    input  wire logic [SYM_W-1:0]      symbol,
    input  wire logic [WORD_BITS-1:0]  code_word,
    input  wire logic [LEN_W-1:0]      code_length,
    // result channel
    output      logic                  result_valid,
    input  wire logic                  result_ready,
    output      logic [BYTE_W-1:0]     out_byte,
    output      logic                  last
);

    // stored code width: the length limit, never wider than the port
    localparam int CODE_W = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam int ADDR_W = $clog2(SYMBOL_COUNT);

    state_t            state_reg;
    state_t            state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              item_xfer;
    logic              slot_free;
    logic              sym_ok;
    logic              tbl_wr_en;
    logic              tbl_rd_en;
    logic [ADDR_W-1:0] tbl_addr;
    logic [CODE_W-1:0] tbl_word;
    logic [LEN_W-1:0]  tbl_len;
    pcbp_ctrl_t        ctrl;
    pcbp_stat_t        stat;

    assign item_ready = (state_reg == ST_IDLE);
    assign item_xfer  = item_valid && item_ready;
    // the output register can take a byte when empty or being emptied
    assign slot_free  = !out_valid_reg || result_ready;
    assign sym_ok     = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign tbl_addr   = symbol[ADDR_W-1:0];

    // Code table: written on a load, read on an encode
    pcbp_code_table #(
        .CODE_W       (CODE_W),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_addr),
        .wr_word (code_word),
        .wr_len  (code_length),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_addr),
        .rd_word (tbl_word),
        .rd_len  (tbl_len)
    );

    // Shared byte shifter
    pcbp_shift_unit #(
        .CODE_W (CODE_W)
    ) u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .code_word (tbl_word),
        .code_len  (tbl_len),
        .stat      (stat)
    );

    // Sequencer: next state, shifter commands and output register loads
    always_comb
    begin
        state_next     = state_reg;
        ctrl           = '0;
        tbl_wr_en      = 1'b0;
        tbl_rd_en      = 1'b0;
        out_valid_next = out_valid_reg && !result_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    unique case (mode)
                        MODE_LOAD:
                        begin
                            // drop loads outside the table
                            tbl_wr_en = sym_ok;
                        end
                        MODE_ENCODE:
                        begin
                            if (sym_ok)
                            begin
                                tbl_rd_en  = 1'b1;
                                state_next = ST_LOOKUP;
                            end
                        end
                        MODE_FLUSH:
                        begin
                            state_next = ST_FLUSH_DATA;
                        end
                        default:
                        begin
                            // unused mode: drop the item
                        end
                    endcase
                end
            end

            ST_LOOKUP:
            begin
                // a symbol without a code appends nothing
                if (tbl_len == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (stat.has_byte)
                begin
                    // advance one byte whenever the output register is free
                    if (slot_free)
                    begin
                        ctrl.step      = 1'b1;
                        out_valid_next = 1'b1;
                        out_byte_next  = stat.byte_data;
                        out_last_next  = stat.final_byte;
                    end
                end
                else
                begin
                    ctrl.settle = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_FLUSH_DATA:
            begin
                // partial byte, zero padded; all zero when nothing pends
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = BYTE_W'(stat.pend_bits);
                    out_last_next  = 1'b0;
                    state_next     = ST_FLUSH_END;
                end
            end

            ST_FLUSH_END:
            begin
                // end byte: number of padding bits, eight when nothing pended
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = BYTE_W'(LEN_W'(BYTE_W) - LEN_W'(stat.pend_count));
                    out_last_next  = 1'b1;
                    ctrl.clear     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the byte until it is taken
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last         = out_last_reg;

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for prefix_code_bit_packer: queued items go through a
// valid/ready driver, and every output byte is checked against a local model
// of the code table and the pending bit buffer.
// ----------------------------------------------------------------------------
module tb;
    import pcbp_pkg::*;

    localparam int MAX_CODE_LEN  = 32;
    localparam int SYMBOL_COUNT  = 256;
    localparam int POOL_SIZE     = 16;       // symbols a phase works with
    localparam int HOLD_CYCLES   = 250;      // long sink hold-off
    localparam int SETTLE_CYCLES = 16;       // covers an item that gives no byte
    localparam int MAX_PRINTED   = 40;
    localparam longint RUN_LIMIT = 3_000_000;  // ns

    // The fourth mode code is not in the package enum; the block must drop it
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]           mode;
        logic [SYM_W-1:0]     sym;
        logic [WORD_BITS-1:0] word;
        logic [LEN_W-1:0]     len;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    // ------------------------------------------------------------------------
    // Clock, ports and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    item_t                 cur_item     = '0;
    logic [1:0]            mode;
    logic [SYM_W-1:0]      symbol;
    logic [WORD_BITS-1:0]  code_word;
    logic [LEN_W-1:0]      code_length;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic                  last;

    // The payload follows the item currently on offer
    assign mode        = cur_item.mode;
    assign symbol      = cur_item.sym;
    assign code_word   = cur_item.word;
    assign code_length = cur_item.len;

    prefix_code_bit_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .symbol       (symbol),
        .code_word    (code_word),
        .code_length  (code_length),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .last         (last)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    item_t        item_q[$];      // items waiting for the driver
    packed_byte_t bytes_due[$];   // bytes the packer still owes, oldest first
    logic         item_fire = 1'b0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    logic         hold_req = 1'b0;
    logic         rx_hold  = 1'b0;
    int           errors     = 0;
    int           bytes_seen = 0;
    int           mode_seen[4];

    // Local copy of the code table and of the bit buffer
    logic [WORD_BITS-1:0] tbl_word[SYMBOL_COUNT];
    logic [LEN_W-1:0]     tbl_len[SYMBOL_COUNT];
    logic [PEND_W-1:0]    pend_bits;
    logic [CNT_W-1:0]     pend_cnt;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Work out the bytes that one accepted item gives and advance the model
    task automatic pack_item(input item_t it);
        logic [63:0]  acc;
        int           total;
        int           len;
        int           lim;
        int           nb;
        packed_byte_t b;
        lim = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
        case (it.mode)
            MODE_LOAD:
            begin
                if (it.sym < SYMBOL_COUNT)
                begin
                    // Saturate the length, then clear code bits above it
                    len = (it.len > lim) ? lim : int'(it.len);
                    if (len < WORD_BITS)
                        tbl_word[it.sym] = WORD_BITS'(64'(it.word) & ((64'd1 << len) - 64'd1));
                    else
                        tbl_word[it.sym] = it.word;
                    tbl_len[it.sym] = len[LEN_W-1:0];
                end
            end
            MODE_ENCODE:
            begin
                len = (it.sym < SYMBOL_COUNT) ? int'(tbl_len[it.sym]) : 0;
                if (len != 0)
                begin
                    acc   = 64'(pend_bits) | (64'(tbl_word[it.sym]) << pend_cnt);
                    total = int'(pend_cnt) + len;
                    nb    = (total / 8 > 4) ? 4 : total / 8;
                    for (int i = 0; i < nb; i++)
                    begin
                        b.data = acc[BYTE_W-1:0];
                        b.last = (i == nb - 1);
                        bytes_due.push_back(b);
                        acc = acc >> 8;
                    end
                    total     = total - 8 * nb;
                    pend_cnt  = total[CNT_W-1:0];
                    pend_bits = acc[PEND_W-1:0] & PEND_W'((8'd1 << pend_cnt) - 8'd1);
                end
            end
            MODE_FLUSH:
            begin
                // Zero-padded partial byte, then the count of padding bits
                b.data = BYTE_W'(pend_bits & PEND_W'((8'd1 << pend_cnt) - 8'd1));
                b.last = 1'b0;
                bytes_due.push_back(b);
                b.data = BYTE_W'(8 - int'(pend_cnt));
                b.last = 1'b1;
                bytes_due.push_back(b);
                pend_bits = '0;
                pend_cnt  = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next queued item on the falling edge, hold it until
    // the transfer has happened
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_fire)
        begin
            if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_item   <= item_q.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Sink: random back-pressure, or a solid hold while a long stall runs
    always @(negedge clk)
        result_ready <= rst_n && !rx_hold && ($urandom_range(99) >= recv_idle_pct);

    // Long sink stall, counted here so the driver keeps offering items
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rx_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold  = 1'b0;
                hold_req = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check output bytes first, then predict from the input transfer
    // taken at the same edge, so a new item never feeds an older byte
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        packed_byte_t want;
        if (result_valid && result_ready)
        begin
            bytes_seen++;
            if (bytes_due.size() == 0)
                report_mismatch($sformatf("byte %02h (last %0b) with nothing expected",
                                          out_byte, last));
            else
            begin
                want = bytes_due.pop_front();
                if (out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, want.data));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                              last, want.last, want.data));
            end
        end
        if (item_valid && item_ready)
        begin
            mode_seen[cur_item.mode]++;
            pack_item(cur_item);
        end
        item_fire <= item_valid && item_ready;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [1:0] m, input logic [SYM_W-1:0] s,
                             input logic [WORD_BITS-1:0] w, input logic [LEN_W-1:0] l);
        item_t it;
        it.mode = m;
        it.sym  = s;
        it.word = w;
        it.len  = l;
        item_q.push_back(it);
    endtask

    // Mostly real code lengths, a fair share of long ones, some zero and
    // some beyond the word width
    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return '0;
        else if (r < 14)
            return LEN_W'($urandom_range(63, 33));
        else if (r < 34)
            return LEN_W'($urandom_range(32, 25));
        else
            return LEN_W'($urandom_range(24, 1));
    endfunction

    // Hold off the sender until the packer has handed over everything owed
    task automatic wait_drained();
        while (item_q.size() != 0 || item_valid || bytes_due.size() != 0 || hold_req)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random phase: load a symbol pool, then a mixed stream that mostly
    // encodes pool symbols, with flushes, reloads and the odd unused mode
    task automatic random_phase(input int items, input bit with_hold);
        logic [SYM_W-1:0] pool[POOL_SIZE];
        logic [SYM_W-1:0] s;
        int r;
        foreach (pool[k])
        begin
            pool[k] = SYM_W'($urandom_range(SYMBOL_COUNT - 1));
            push_item(MODE_LOAD, pool[k], $urandom(), pick_len());
        end
        if (with_hold)
        begin
            // Full-width code, then stall the sink while encodes pile up
            push_item(MODE_LOAD, pool[0], $urandom(), LEN_W'(WORD_BITS));
            wait_drained();
            hold_req = 1'b1;
            for (int i = 0; i < 24; i++)
                push_item(MODE_ENCODE, pool[0], $urandom(), LEN_W'($urandom()));
        end
        for (int i = 0; i < items; i++)
        begin
            if (i == items / 2)
                wait_drained();
            r = $urandom_range(99);
            s = ($urandom_range(9) != 0) ? pool[$urandom_range(POOL_SIZE - 1)]
                                         : SYM_W'($urandom_range(SYMBOL_COUNT - 1));
            if (r < 10)
                push_item(MODE_LOAD, s, $urandom(), pick_len());
            else if (r < 82)
                push_item(MODE_ENCODE, s, $urandom(), LEN_W'($urandom()));
            else if (r < 95)
                push_item(MODE_FLUSH, s, $urandom(), LEN_W'($urandom()));
            else
                push_item(MODE_UNUSED, s, $urandom(), LEN_W'($urandom()));
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (tbl_len[k])
        begin
            tbl_word[k] = '0;
            tbl_len[k]  = '0;
        end
        pend_bits = '0;
        pend_cnt  = '0;
        foreach (mode_seen[k])
            mode_seen[k] = 0;

        // First idling pattern: sender busier than sink
        send_idle_pct = 35;
        recv_idle_pct = 46;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part
        push_item(MODE_ENCODE, 8'h00, '0, '0);                 // table empty: no byte
        push_item(MODE_FLUSH, 8'h00, '0, '0);                  // nothing pending
        push_item(MODE_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
        push_item(MODE_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd63);     // length saturates
        push_item(MODE_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd1);      // upper bits dropped
        push_item(MODE_LOAD, 8'h02, 32'hAAAA_5555, 6'd40);
        push_item(MODE_LOAD, 8'h03, 32'h0000_0000, 6'd7);
        push_item(MODE_LOAD, 8'h04, 32'h1234_5678, 6'd0);      // no code
        push_item(MODE_LOAD, 8'h05, 32'hFFFF_FFD5, 6'd7);
        push_item(MODE_ENCODE, 8'h01, '0, '0);
        push_item(MODE_ENCODE, 8'h01, '0, '0);
        push_item(MODE_ENCODE, 8'h03, '0, '0);                 // crosses one byte
        push_item(MODE_ENCODE, 8'h00, '0, '0);                 // 33 bits: four bytes
        push_item(MODE_ENCODE, 8'h04, '0, '0);                 // zero length
        push_item(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        push_item(MODE_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        push_item(MODE_ENCODE, 8'h05, '0, '0);                 // seven pending
        push_item(MODE_ENCODE, 8'hFF, '0, '0);                 // 39 bits: four bytes
        push_item(MODE_FLUSH, 8'h00, '0, '0);
        push_item(MODE_ENCODE, 8'h02, '0, '0);                 // byte aligned
        push_item(MODE_ENCODE, 8'h05, '0, '0);
        push_item(MODE_FLUSH, 8'h00, '0, '0);
        push_item(MODE_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0);      // erase a code
        push_item(MODE_ENCODE, 8'h00, '0, '0);
        wait_drained();

        random_phase(130, 1'b0);

        // Swap the idling pattern
        send_idle_pct = 46;
        recv_idle_pct = 35;
        random_phase(130, 1'b0);

        // No idling; the long sink stall goes here
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(106, 1'b1);

        $display("Covered %0d loads, %0d encodes, %0d flushes, %0d unused-mode items",
                 mode_seen[MODE_LOAD], mode_seen[MODE_ENCODE], mode_seen[MODE_FLUSH],
                 mode_seen[MODE_UNUSED]);
        $display("Checked %0d output bytes under three idling patterns and a long stall",
                 bytes_seen);
        if (errors == 0)
            $display("prefix_code_bit_packer verification clean");
        else
            $display("prefix_code_bit_packer verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("prefix_code_bit_packer verification failed");
        $finish;
    end

endmodule
